[src/mpr_pkg.sv]
package mpr_pkg;

  localparam int unsigned LineMaxDefault = 512;

  localparam int unsigned PixW = 8;
  localparam int unsigned CfgLenW = 10;
  localparam int unsigned CfgDataW = 10;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [CfgLenW-1:0] LineLengthReset = CfgLenW'(240);
  localparam logic [PixW-1:0] BorderReset = '0;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LINE_LENGTH = 1'b0,
    CFG_BORDER_VALUE = 1'b1
  } cfg_idx_e;

endpackage

[src/med_prediction_residual.sv]
// An accepted transaction is registered in the read stage (s1), then in the output
// register. Throughput: one pixel per cycle unless the output stalls;
// the line store reads and writes one entry each cycle.
// The output register plus the read stage give two transactions of slack under stall.
// Reset (rst_ni low, async): pipeline empty, column 0, first-line mode,
// line_length 240, border_value 0. Line store contents are not cleared.
module med_prediction_residual #(
  parameter int unsigned LineMax = mpr_pkg::LineMaxDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // pixel input channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [mpr_pkg::PixW-1:0]     pixel_i,
  input  logic                         frame_start_i,
  // residual output channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [mpr_pkg::PixW-1:0]     residual_o,
  output logic                         line_end_o,
  // configuration writes
  input  logic                         cfg_we_i,
  input  logic [mpr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mpr_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned AddrW = $clog2(LineMax);
  // width wide enough for both the register value and LineMax itself
  localparam int unsigned CmpW = (AddrW + 1 > mpr_pkg::CfgLenW) ? AddrW + 1 : mpr_pkg::CfgLenW;
  localparam logic [CmpW-1:0] LineMaxC = CmpW'(LineMax);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [mpr_pkg::CfgLenW-1:0] line_length_q;
  logic [mpr_pkg::PixW-1:0]    border_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_length_q <= mpr_pkg::LineLengthReset;
      border_q      <= mpr_pkg::BorderReset;
    end else if (cfg_we_i) begin
      unique case (mpr_pkg::cfg_idx_e'(cfg_idx_i))
        mpr_pkg::CFG_LINE_LENGTH: line_length_q <= cfg_data_i[mpr_pkg::CfgLenW-1:0];
        mpr_pkg::CFG_BORDER_VALUE: border_q <= cfg_data_i[mpr_pkg::PixW-1:0];
        default: ;
      endcase
    end
  end

  // Effective line length: 0 counts as 1, anything above LineMax as LineMax.
  logic [CmpW-1:0] len_raw, len_eff;

  always_comb begin
    len_raw = CmpW'(line_length_q);
    if (len_raw == '0) begin
      len_eff = CmpW'(1);
    end else if (len_raw > LineMaxC) begin
      len_eff = LineMaxC;
    end else begin
      len_eff = len_raw;
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: read stage (s1) feeds the output register
  // ---------------------------------------------------------------------------
  logic s1_valid_q;
  logic out_valid_q;
  logic s1_adv, accept;

  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign accept     = in_valid_i && !in_stall_o;

  // ---------------------------------------------------------------------------
  // Accept stage: column tracking, line store read and write of the same entry
  // ---------------------------------------------------------------------------
  logic [AddrW-1:0]        col_q;
  logic                    first_q;
  logic [mpr_pkg::PixW-1:0] left_q;

  logic [AddrW-1:0] col;
  logic             first;
  logic [CmpW-1:0]  col_inc;
  logic             last;

  always_comb begin
    col     = frame_start_i ? '0 : col_q;
    first   = frame_start_i || first_q;
    col_inc = CmpW'(col) + CmpW'(1);
    last    = (col_inc >= len_eff);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      first_q <= 1'b1;
      left_q  <= '0;
    end else if (accept) begin
      left_q <= pixel_i;
      if (last) begin
        col_q   <= '0;
        first_q <= 1'b0;
      end else begin
        col_q   <= col_inc[AddrW-1:0];
        first_q <= first;
      end
    end
  end

  // Read-first RAM: the read returns the previous line's sample while this
  // pixel overwrites it. A later line reads the entry only after the write
  // has taken effect, so no forwarding is needed.
  logic [mpr_pkg::PixW-1:0] above_rd;

  mpr_ram #(
    .Width (mpr_pkg::PixW),
    .Depth (LineMax)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (col),
    .wdata_i (pixel_i),
    .re_i    (accept),
    .raddr_i (col),
    .rdata_o (above_rd)
  );

  // s1 payload held in place while stalled (RAM read data holds too)
  logic [mpr_pkg::PixW-1:0] s1_pix_q, s1_left_q;
  logic                     s1_col0_q, s1_first_q, s1_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q   <= pixel_i;
      s1_left_q  <= left_q;
      s1_col0_q  <= (col == '0);
      s1_first_q <= first;
      s1_last_q  <= last;
    end
  end

  // ---------------------------------------------------------------------------
  // Prediction stage
  // ---------------------------------------------------------------------------
  logic [mpr_pkg::PixW-1:0] ul_q;  // b of the previous transaction
  logic [mpr_pkg::PixW-1:0] nb_a, nb_b, nb_c, res;

  assign nb_b = s1_first_q ? border_q : above_rd;
  assign nb_a = s1_col0_q ? border_q : s1_left_q;
  assign nb_c = s1_col0_q ? border_q : ul_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ul_q <= '0;
    end else if (s1_adv) begin
      ul_q <= nb_b;
    end
  end

  mpr_med u_med (
    .pix_i      (s1_pix_q),
    .a_i        (nb_a),
    .b_i        (nb_b),
    .c_i        (nb_c),
    .residual_o (res)
  );

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic [mpr_pkg::PixW-1:0] out_res_q;
  logic                     out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_res_q  <= res;
      out_last_q <= s1_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign residual_o  = out_res_q;
  assign line_end_o  = out_last_q;

`ifndef NO_ASSERTIONS
  a_accept_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_valid_q)
    else $error("accepted transaction missing from read stage");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled with room in the pipeline");

  a_line_end_leaves_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last) |=> (!first_q && col_q == '0))
    else $error("line end did not wrap column or leave first-line mode");

  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CmpW'(col_q) < LineMaxC)
    else $error("column beyond line store depth");
`endif

endmodule

[src/mpr_ram.sv]
module mpr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // read-first: a read and a write to one entry in a cycle return the old data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/mpr_med.sv]
module mpr_med (
  input  logic [mpr_pkg::PixW-1:0] pix_i,
  input  logic [mpr_pkg::PixW-1:0] a_i,
  input  logic [mpr_pkg::PixW-1:0] b_i,
  input  logic [mpr_pkg::PixW-1:0] c_i,
  output logic [mpr_pkg::PixW-1:0] residual_o
);

  logic [mpr_pkg::PixW-1:0] lo, hi, pred;

  always_comb begin
    lo = (a_i < b_i) ? a_i : b_i;
    hi = (a_i < b_i) ? b_i : a_i;
    if (c_i >= hi) begin
      pred = lo;
    end else if (c_i <= lo) begin
      pred = hi;
    end else begin
      // wraps mod 256, matches the gradient term
      pred = a_i + b_i - c_i;
    end
    residual_o = pix_i - pred;
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned LineDepth = mpr_pkg::LineMaxDefault;
  localparam int unsigned RandomItems = 1650;
  // Output passes the read stage and the output register after acceptance; this margin covers it.
  localparam int unsigned DrainCycles = 8;
  // Bound for the slowest legal run of ~1700 transactions under full idling
  // on both sides, with a wide margin.
  localparam int unsigned CycleLimit = 400000;

  typedef struct packed {
    logic [mpr_pkg::PixW-1:0] pix;
    logic                     fs;
  } pix_item_t;

  typedef struct packed {
    logic [mpr_pkg::PixW-1:0] residual;
    logic                     line_end;
  } res_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic                         in_valid_i = 1'b0;
  logic                         in_stall_o;
  logic [mpr_pkg::PixW-1:0]     pixel_i = '0;
  logic                         frame_start_i = 1'b0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  logic [mpr_pkg::PixW-1:0]     residual_o;
  logic                         line_end_o;
  logic                         cfg_we_i = 1'b0;
  logic [mpr_pkg::CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [mpr_pkg::CfgDataW-1:0] cfg_data_i = '0;

  med_prediction_residual uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .pixel_i      (pixel_i),
    .frame_start_i(frame_start_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .residual_o   (residual_o),
    .line_end_o   (line_end_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  // Pixels waiting for the driver, and residuals waiting for the monitor.
  pix_item_t pending_px[$];
  res_t      expected_res[$];

  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;

  // Idle rates in percent per opportunity; each hit opens an idle burst.
  int unsigned drv_gap_pct = 0;
  int unsigned rcv_stall_pct = 0;

  // ---------------------------------------------------------------------------
  // Predictor: own copy of line store, neighbors, column and config.
  // ---------------------------------------------------------------------------
  logic [mpr_pkg::PixW-1:0]    line_mem [LineDepth];
  logic [mpr_pkg::PixW-1:0]    left_px;
  logic [mpr_pkg::PixW-1:0]    upleft_px;
  int unsigned                 col_pos;
  logic                        in_first_line;
  logic [mpr_pkg::CfgLenW-1:0] cfg_len;
  logic [mpr_pkg::PixW-1:0]    cfg_border;

  // Line length as the block uses it: 0 acts as 1, anything past the
  // store depth acts as the full depth.
  function automatic int unsigned clamp_line_len(logic [mpr_pkg::CfgLenW-1:0] raw);
    if (raw == 0) return 1;
    if (raw > LineDepth) return LineDepth;
    return raw;
  endfunction

  // Median edge detector over left (a), above (b), upper-left (c).
  function automatic logic [mpr_pkg::PixW-1:0] med_estimate(logic [mpr_pkg::PixW-1:0] a,
                                                            logic [mpr_pkg::PixW-1:0] b,
                                                            logic [mpr_pkg::PixW-1:0] c);
    logic [mpr_pkg::PixW-1:0] lo, hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (c >= hi) return lo;
    if (c <= lo) return hi;
    return a + b - c;
  endfunction

  function automatic res_t predict_residual(pix_item_t it);
    int unsigned              len_eff;
    int unsigned              col;
    logic [mpr_pkg::PixW-1:0] a, b, c;
    res_t                     r;
    len_eff = clamp_line_len(cfg_len);
    // frame start restarts the column and re-enters first-line mode
    if (it.fs) begin
      col_pos = 0;
      in_first_line = 1'b1;
    end
    col = col_pos;
    if (col >= LineDepth) col = 0;
    b = in_first_line ? cfg_border : line_mem[col];
    if (col == 0) begin
      a = cfg_border;
      c = cfg_border;
    end else begin
      a = left_px;
      c = upleft_px;
    end
    r.residual = it.pix - med_estimate(a, b, c);
    line_mem[col] = it.pix;
    left_px = it.pix;
    upleft_px = b;
    // a shortened line ends right here if the column is already past it
    col++;
    r.line_end = (col >= len_eff);
    if (r.line_end) begin
      col = 0;
      in_first_line = 1'b0;
    end
    col_pos = col;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_cnt++;
    $display("%0t ns MISMATCH: %s", $realtime, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Clock and cycle limit
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: presents pending pixels, holds each until accepted, predicts on
  // acceptance. Gaps only open between transactions.
  // ---------------------------------------------------------------------------
  pix_item_t   drv_item;
  int unsigned drv_gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i    <= 1'b0;
      pixel_i       <= '0;
      frame_start_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) expected_res.push_back(predict_residual(drv_item));
      if (!in_valid_i || !in_stall_o) begin
        if (drv_gap_left > 0) begin
          drv_gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_px.size() != 0 && drv_gap_pct != 0 &&
                     $urandom_range(0, 99) < drv_gap_pct) begin
          drv_gap_left = $urandom_range(0, 14);
          in_valid_i <= 1'b0;
        end else if (pending_px.size() != 0) begin
          drv_item = pending_px.pop_front();
          in_valid_i    <= 1'b1;
          pixel_i       <= drv_item.pix;
          frame_start_i <= drv_item.fs;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each output transaction against the oldest expectation,
  // and drives stall bursts.
  // ---------------------------------------------------------------------------
  res_t        rcv_want;
  int unsigned rcv_stall_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_res.size() == 0) begin
          report_mismatch($sformatf("unexpected transaction residual=%02h line_end=%0b",
                                    residual_o, line_end_o));
        end else begin
          rcv_want = expected_res.pop_front();
          if (residual_o !== rcv_want.residual)
            report_mismatch($sformatf("residual got %02h want %02h",
                                      residual_o, rcv_want.residual));
          if (line_end_o !== rcv_want.line_end)
            report_mismatch($sformatf("line_end got %0b want %0b",
                                      line_end_o, rcv_want.line_end));
        end
      end
      if (rcv_stall_left > 0) begin
        rcv_stall_left--;
        out_stall_i <= 1'b1;
      end else if (rcv_stall_pct != 0 && $urandom_range(0, 99) < rcv_stall_pct) begin
        rcv_stall_left = $urandom_range(0, 14);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  // Effective line length the stimulus is currently built for.
  int unsigned gen_len;
  logic [mpr_pkg::PixW-1:0] gen_last_px = '0;

  // Wait until the block is drained: nothing pending, nothing in flight.
  task automatic settle();
    do @(negedge clk_i);
    while (pending_px.size() != 0 || in_valid_i || expected_res.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_cfg(mpr_pkg::cfg_idx_e idx, logic [mpr_pkg::CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == mpr_pkg::CFG_LINE_LENGTH) cfg_len = data;
    else cfg_border = data[mpr_pkg::PixW-1:0];
  endtask

  // Both registers, written while idle. A longer line would read store
  // entries never written, so a raise forces a new frame on the next pixel.
  task automatic configure(logic [mpr_pkg::CfgDataW-1:0] len_raw,
                           logic [mpr_pkg::CfgDataW-1:0] border_raw,
                           output bit raised);
    int unsigned new_len;
    settle();
    write_cfg(mpr_pkg::CFG_LINE_LENGTH, len_raw);
    write_cfg(mpr_pkg::CFG_BORDER_VALUE, border_raw);
    new_len = clamp_line_len(len_raw);
    raised = (new_len > gen_len);
    gen_len = new_len;
  endtask

  task automatic push_px(logic [mpr_pkg::PixW-1:0] pix, logic fs);
    pix_item_t it;
    it.pix = pix;
    it.fs  = fs;
    pending_px.push_back(it);
  endtask

  // Mostly whole frames of 1..4 lines; now and then a frame start lands
  // mid-line, or a frame just runs on without one.
  task automatic feed_pixels(int unsigned n, bit open_frame);
    int unsigned              i;
    int unsigned              frame_left;
    logic                     fs;
    logic [mpr_pkg::PixW-1:0] pix;
    @(negedge clk_i);
    frame_left = 0;
    for (i = 0; i < n; i++) begin
      if (i == 0) fs = open_frame;
      else if (frame_left == 0) fs = ($urandom_range(0, 7) != 0);
      else fs = ($urandom_range(0, 79) == 0);
      if (fs || frame_left == 0) frame_left = gen_len * $urandom_range(1, 4);
      frame_left--;
      case ($urandom_range(0, 7))
        0:       pix = '0;
        1:       pix = '1;
        2, 3:    pix = gen_last_px + mpr_pkg::PixW'($urandom_range(0, 6)) - mpr_pkg::PixW'(3);
        default: pix = mpr_pkg::PixW'($urandom());
      endcase
      gen_last_px = pix;
      push_px(pix, fs);
    end
  endtask

  initial begin
    bit                          raised;
    int unsigned                 random_cnt;
    int unsigned                 phase;
    int unsigned                 n;
    logic [mpr_pkg::CfgLenW-1:0] len_raw;
    logic [mpr_pkg::PixW-1:0]    border;

    // predictor state after reset
    foreach (line_mem[k]) line_mem[k] = '0;
    left_px       = '0;
    upleft_px     = '0;
    col_pos       = 0;
    in_first_line = 1'b1;
    cfg_len       = mpr_pkg::LineLengthReset;
    cfg_border    = mpr_pkg::BorderReset;
    gen_len       = clamp_line_len(mpr_pkg::LineLengthReset);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // --- directed ---
    // 3-pixel lines, border all ones; stream starts without a frame start
    // and runs in first-line mode, then a second line reads the store.
    configure(10'd3, {2'b11, 8'hFF}, raised);
    @(negedge clk_i);
    push_px(8'h00, 1'b0); push_px(8'hFF, 1'b0); push_px(8'h55, 1'b0);
    push_px(8'hAA, 1'b0); push_px(8'h00, 1'b0); push_px(8'hFF, 1'b0);
    push_px(8'h12, 1'b1); push_px(8'h80, 1'b0); push_px(8'h7F, 1'b0);
    push_px(8'h01, 1'b0); push_px(8'hFE, 1'b0); push_px(8'h80, 1'b0);

    // zero length acts as one: every pixel sits in column zero and ends a line
    configure('0, '0, raised);
    @(negedge clk_i);
    push_px(8'hFF, 1'b0); push_px(8'h00, 1'b0); push_px(8'h81, 1'b0);
    push_px(8'h7E, 1'b1);

    // longer line, new frame; stop mid-line at column 5
    configure(10'd6, 10'h05A, raised);
    @(negedge clk_i);
    push_px(8'h10, 1'b1); push_px(8'h20, 1'b0); push_px(8'h30, 1'b0);
    push_px(8'h40, 1'b0); push_px(8'h50, 1'b0);

    // shorten below the current column: next pixel ends the line at once
    configure(10'd3, 10'h0A5, raised);
    @(negedge clk_i);
    push_px(8'h60, 1'b0); push_px(8'h05, 1'b0); push_px(8'h06, 1'b0);
    push_px(8'h07, 1'b0);

    // --- random ---
    random_cnt = 0;
    phase = 0;
    while (random_cnt < RandomItems) begin
      phase++;
      if (phase == 3) begin
        len_raw = '1;      // clamps to the full store depth
      end else if (phase == 4) begin
        len_raw = mpr_pkg::CfgLenW'(LineDepth);
      end else begin
        case ($urandom_range(0, 9))
          0:       len_raw = '0;
          1, 2:    len_raw = mpr_pkg::CfgLenW'($urandom_range(17, 64));
          default: len_raw = mpr_pkg::CfgLenW'($urandom_range(1, 16));
        endcase
      end
      case ($urandom_range(0, 5))
        0:       border = '0;
        1:       border = '1;
        default: border = mpr_pkg::PixW'($urandom());
      endcase
      configure(len_raw,
                {mpr_pkg::CfgDataW'($urandom_range(0, 3)) << mpr_pkg::PixW} |
                  mpr_pkg::CfgDataW'(border),
                raised);
      if (phase == 3) n = gen_len + 18;
      else if (phase == 4) n = 40;
      else begin
        n = gen_len * $urandom_range(2, 6) + $urandom_range(0, gen_len);
        if (n > 200) n = 200;
      end
      // varied idling per phase, none in the closing stretch
      if (random_cnt + n + 250 >= RandomItems) begin
        drv_gap_pct   = 0;
        rcv_stall_pct = 0;
      end else begin
        case ($urandom_range(0, 2))
          0:       drv_gap_pct = 0;
          1:       drv_gap_pct = 8;
          default: drv_gap_pct = 30;
        endcase
        case ($urandom_range(0, 2))
          0:       rcv_stall_pct = 0;
          1:       rcv_stall_pct = 8;
          default: rcv_stall_pct = 30;
        endcase
      end
      feed_pixels(n, raised || ($urandom_range(0, 2) == 0));
      random_cnt += n;
    end

    settle();
    if (mismatch_cnt == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
